/* rtl/b58_pkg.sv */
// Shared constants and helpers of the Base58 encoder.
// Holds the radix, the alphabet lookup and common widths; no dependencies.
package b58_pkg;

  localparam int DIGIT_W = 6;
  localparam int DIGIT_SLOTS = 64;
  localparam int TOTAL_W = 7;
  localparam int CHAR_W = 7;

  localparam logic [6:0] RADIX = 7'd58;
  localparam logic [CHAR_W-1:0] ZERO_CHAR = 7'h31;

  localparam logic [0:57][7:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // Maps a digit value to its character; codes above 57 never occur.
  function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] c;
    c = 8'h31;
    if (d < DIGIT_W'(58)) begin
      c = ALPHABET[d];
    end
    return c[CHAR_W-1:0];
  endfunction

endpackage

/* rtl/b58_byte_if.sv */
// Input channel of the Base58 encoder: one byte of the number per word.
// Standalone interface; no dependencies.
interface b58_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source(output valid, output data_byte, output end_of_string, input ready);
  modport sink(input valid, input data_byte, input end_of_string, output ready);
endinterface

/* rtl/b58_char_if.sv */
// Output channel of the Base58 encoder: one text character per word.
// Standalone interface; no dependencies.
interface b58_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] text_char;
  logic       final_char;
  logic       overflowed;

  modport source(output valid, output text_char, output final_char, output overflowed,
                 input ready);
  modport sink(input valid, input text_char, input final_char, input overflowed,
               output ready);
endinterface

/* rtl/b58_div_step.sv */
// One long-division step: (rem * 256 + byte) divided by 58.
// Restoring division over the eight bits of the byte; uses b58_pkg.
module b58_div_step import b58_pkg::*; (
  input  logic [DIGIT_W-1:0] rem_in,
  input  logic [7:0]         byte_in,
  output logic [7:0]         quot,
  output logic [DIGIT_W-1:0] rem_out
);

  always_comb begin
    logic [6:0] r;
    r = {1'b0, rem_in};
    quot = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[5:0], byte_in[i]};
      if (r >= RADIX) begin
        r = r - RADIX;
        quot[i] = 1'b1;
      end
    end
    rem_out = r[DIGIT_W-1:0];
  end

endmodule

/* rtl/base58_encoder_unit.sv */
// Base58 encoder top level: byte store, division sequencer and text emitter.
// Depends on b58_pkg, b58_byte_if, b58_char_if and b58_div_step.
//
// Usage: bytes of a big-endian number arrive on the bytes channel, one per
// word, with end_of_string on the last. A byte arriving when MAX_BYTES are
// already held is dropped and the string is flagged as overflowed. After the
// last byte the block divides the stored number by 58 in place, one pass per
// digit; a pass walks the still-nonzero bytes, each in a memory read state
// followed by a divide step and write back state. The passes shorten as the
// high bytes run out. The text then leaves on the chars channel, each
// character through a read state and an output state: a '1' per leading
// zero byte, then the digits most significant first, at most MAX_CHARS
// characters, with the last one marked. Bytes are accepted only while no
// string is being encoded, but the last character may still wait in the
// output register while the next string loads. A stalled receiver simply
// holds the emitter. Reset clears the control state at once; the byte and
// digit memories need no clearing pass.
module base58_encoder_unit import b58_pkg::*; #(
  parameter int MAX_BYTES = 40,
  parameter int MAX_CHARS = 55
) (
  input  logic clk,
  input  logic rst,
  b58_byte_if.sink   bytes,
  b58_char_if.source chars
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_RD,
    S_DIV_WR,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t state;

  logic [CW-1:0]      byte_count;
  logic [CW-1:0]      lz;
  logic               seen_nonzero;
  logic               overflow_flag;
  logic [AW-1:0]      idx;
  logic [DIGIT_W-1:0] rem;
  logic               pass_nz;
  logic [CW-1:0]      pass_first;
  logic [DIGIT_W-1:0] ndig;
  logic [TOTAL_W-1:0] k;

  logic               out_valid;
  logic [CHAR_W-1:0]  out_char;
  logic               out_final;
  logic               out_ovf;

  // Byte store and digit store.
  logic [7:0]         num_mem [MAX_BYTES];
  logic [7:0]         num_rdata;
  logic               num_we;
  logic [AW-1:0]      num_waddr;
  logic [7:0]         num_wdata;
  logic [DIGIT_W-1:0] dig_mem [DIGIT_SLOTS];
  logic [DIGIT_W-1:0] dig_rdata;
  logic               dig_we;
  logic [DIGIT_W-1:0] dig_raddr;

  // Input side.
  logic               in_acc;
  logic               can_store;
  logic [CW-1:0]      cnt_n;
  logic [CW-1:0]      lz_n;

  // Division side.
  logic [7:0]         quot;
  logic [DIGIT_W-1:0] rem_out;
  logic               pass_end;
  logic [CW-1:0]      next_first;

  // Emission side.
  logic [TOTAL_W-1:0] total;
  logic               trunc;
  logic [TOTAL_W-1:0] emit_n;
  logic               in_zero_run;
  logic               out_free;
  logic               is_final;
  logic               load_out;
  logic               load_final;

  b58_div_step u_div (
    .rem_in  (rem),
    .byte_in (num_rdata),
    .quot    (quot),
    .rem_out (rem_out)
  );

  assign bytes.ready = (state == S_IDLE);
  assign in_acc      = bytes.valid && (state == S_IDLE);
  assign can_store   = byte_count < CW'(MAX_BYTES);
  assign cnt_n       = can_store ? byte_count + CW'(1) : byte_count;
  assign lz_n        = (can_store && !seen_nonzero && bytes.data_byte == 8'd0)
                       ? lz + CW'(1) : lz;

  assign pass_end   = (CW'(idx) + CW'(1)) == byte_count;
  assign next_first = pass_nz ? pass_first : ((quot != 8'd0) ? CW'(idx) : byte_count);

  always_comb begin
    num_we    = 1'b0;
    num_waddr = idx;
    num_wdata = quot;
    if (in_acc && can_store) begin
      num_we    = 1'b1;
      num_waddr = byte_count[AW-1:0];
      num_wdata = bytes.data_byte;
    end else if (state == S_DIV_WR) begin
      num_we = 1'b1;
    end
  end

  assign dig_we = (state == S_DIV_WR) && pass_end;

  always_ff @(posedge clk) begin
    if (num_we) begin
      num_mem[num_waddr] <= num_wdata;
    end
    num_rdata <= num_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (dig_we) begin
      dig_mem[ndig] <= rem_out;
    end
    dig_rdata <= dig_mem[dig_raddr];
  end

  assign total       = TOTAL_W'(lz) + TOTAL_W'(ndig);
  assign trunc       = total > TOTAL_W'(MAX_CHARS);
  assign emit_n      = trunc ? TOTAL_W'(MAX_CHARS) : total;
  assign in_zero_run = k < TOTAL_W'(lz);
  // Digits sit least significant first, so the text walks them downward.
  assign dig_raddr   = ndig - DIGIT_W'(1) - DIGIT_W'(k - TOTAL_W'(lz));
  assign out_free    = !out_valid || chars.ready;
  assign is_final    = (k + TOTAL_W'(1)) == emit_n;
  assign load_out    = (state == S_EMIT_OUT) && out_free;
  assign load_final  = load_out && is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_count    <= '0;
      lz            <= '0;
      seen_nonzero  <= 1'b0;
      overflow_flag <= 1'b0;
      idx           <= '0;
      rem           <= '0;
      pass_nz       <= 1'b0;
      pass_first    <= '0;
      ndig          <= '0;
      k             <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            byte_count    <= cnt_n;
            lz            <= lz_n;
            overflow_flag <= overflow_flag | !can_store;
            if (can_store && bytes.data_byte != 8'd0) begin
              seen_nonzero <= 1'b1;
            end
            if (bytes.end_of_string) begin
              ndig    <= '0;
              k       <= '0;
              rem     <= '0;
              pass_nz <= 1'b0;
              idx     <= lz_n[AW-1:0];
              // An all-zero string has no digits at all.
              state   <= (lz_n == cnt_n) ? S_EMIT_RD : S_DIV_RD;
            end
          end
        end
        S_DIV_RD: begin
          state <= S_DIV_WR;
        end
        S_DIV_WR: begin
          if (pass_end) begin
            ndig <= ndig + DIGIT_W'(1);
            rem  <= '0;
            pass_nz <= 1'b0;
            if (next_first == byte_count) begin
              state <= S_EMIT_RD;
            end else begin
              idx   <= next_first[AW-1:0];
              state <= S_DIV_RD;
            end
          end else begin
            idx <= idx + AW'(1);
            rem <= rem_out;
            if (!pass_nz && quot != 8'd0) begin
              pass_nz    <= 1'b1;
              pass_first <= CW'(idx);
            end
            state <= S_DIV_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_free) begin
            out_char  <= in_zero_run ? ZERO_CHAR : b58_char(dig_rdata);
            out_final <= is_final;
            out_ovf   <= overflow_flag | trunc;
            if (is_final) begin
              byte_count    <= '0;
              lz            <= '0;
              seen_nonzero  <= 1'b0;
              overflow_flag <= 1'b0;
              state         <= S_IDLE;
            end else begin
              k     <= k + TOTAL_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign chars.valid      = out_valid;
  assign chars.text_char  = out_char;
  assign chars.final_char = out_final;
  assign chars.overflowed = out_ovf;

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    (byte_count <= CW'(MAX_BYTES)) && (lz <= byte_count))
    else $error("byte or leading zero count out of range");

  a_div_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_WR) |-> (CW'(idx) < byte_count))
    else $error("division index beyond stored bytes");

  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_RD) |=> (state == S_DIV_WR))
    else $error("division read not followed by write back");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    load_final |=> (state == S_IDLE) && (byte_count == '0) && out_valid && chars.final_char)
    else $error("string state not cleared after last character");

endmodule

/* dv/tb_top.sv */
// Testbench for base58_encoder_unit: byte strings in, Base58 characters out.
// Depends on b58_pkg, b58_byte_if, b58_char_if and base58_encoder_unit; predicts every character itself.
`timescale 1ns / 100ps

module tb_top;
  import b58_pkg::*;

  localparam int STORE_BYTES = 40;
  localparam int TEXT_CHARS = 55;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] FULL_BYTE = 8'hFF;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              final_char;
    logic              overflowed;
  } char_word_t;

  logic clk = 1'b0;
  logic rst;

  b58_byte_if byte_ch ();
  b58_char_if char_ch ();

  base58_encoder_unit #(
    .MAX_BYTES(STORE_BYTES),
    .MAX_CHARS(TEXT_CHARS)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .bytes(byte_ch),
    .chars(char_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state for the string being loaded.
  logic [7:0]  held_bytes [STORE_BYTES];
  int unsigned held_count;
  int unsigned zero_prefix;
  bit          nonzero_seen;
  bit          bytes_dropped;
  char_word_t  text_due [$];

  int  mismatch_count = 0;
  int  sent_count = 0;
  bit  idle_on = 1'b0;
  bit  took_word = 1'b0;
  int  hold_asks = 0;

  logic [7:0] str_buf [64];
  int         str_len;

  // Digit value to character; the alphabet skips 0, I, O and l.
  function automatic logic [CHAR_W-1:0] digit_symbol(input int unsigned d);
    if (d < 9) return CHAR_W'(8'h31 + d);
    if (d < 17) return CHAR_W'(8'h41 + d - 9);
    if (d < 22) return CHAR_W'(8'h4A + d - 17);
    if (d < 33) return CHAR_W'(8'h50 + d - 22);
    if (d < 44) return CHAR_W'(8'h61 + d - 33);
    return CHAR_W'(8'h6D + d - 44);
  endfunction

  // Stores one accepted byte; on the end flag, queues the expected text.
  function automatic void take_byte_and_encode(input logic [7:0] b, input logic last);
    logic [7:0]  work [STORE_BYTES];
    int unsigned digits [64];
    int unsigned ndig;
    int unsigned first;
    int unsigned rem;
    int unsigned acc;
    int unsigned total;
    int unsigned emit;
    bit          cut;
    char_word_t  w;

    if (held_count < STORE_BYTES) begin
      held_bytes[held_count] = b;
      held_count++;
      if (!nonzero_seen) begin
        if (b == ZERO_BYTE) zero_prefix++;
        else nonzero_seen = 1'b1;
      end
    end else begin
      bytes_dropped = 1'b1;
    end
    if (!last) return;

    // Long division by 58 over the significant bytes, one digit per pass.
    work = held_bytes;
    first = zero_prefix;
    ndig = 0;
    while (first < held_count) begin
      rem = 0;
      for (int i = first; i < held_count; i++) begin
        acc = rem * 256 + work[i];
        work[i] = 8'(acc / 58);
        rem = acc % 58;
      end
      digits[ndig] = rem;
      ndig++;
      while (first < held_count && work[first] == ZERO_BYTE) first++;
    end

    total = zero_prefix + ndig;
    emit = (total > TEXT_CHARS) ? TEXT_CHARS : total;
    cut = bytes_dropped || (total > TEXT_CHARS);
    for (int unsigned k = 0; k < emit; k++) begin
      if (k < zero_prefix) w.text_char = ZERO_CHAR;
      else w.text_char = digit_symbol(digits[ndig - 1 - (k - zero_prefix)]);
      w.final_char = (k + 1 == emit);
      w.overflowed = cut;
      text_due.push_back(w);
    end

    held_count = 0;
    zero_prefix = 0;
    nonzero_seen = 1'b0;
    bytes_dropped = 1'b0;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.end_of_string <= last;
    do @(posedge clk); while (!byte_ch.ready);
    take_byte_and_encode(b, last);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_string();
    for (int i = 0; i < str_len; i++) send_byte(str_buf[i], i == str_len - 1);
  endtask

  task automatic fill_random_string();
    int kind;
    int zeros;
    int pick;
    bit all_zero;
    kind = $urandom_range(0, 9);
    if (kind < 6) str_len = $urandom_range(1, 8);
    else if (kind < 9) str_len = $urandom_range(9, 24);
    else str_len = $urandom_range(25, STORE_BYTES);
    if ($urandom_range(0, 19) == 0) str_len = $urandom_range(STORE_BYTES + 1, STORE_BYTES + 4);
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    all_zero = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < str_len; i++) begin
      pick = $urandom_range(0, 7);
      if (all_zero || i < zeros) str_buf[i] = ZERO_BYTE;
      else if (pick == 0) str_buf[i] = ZERO_BYTE;
      else if (pick == 1) str_buf[i] = FULL_BYTE;
      else str_buf[i] = 8'($urandom_range(0, 255));
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Check each character word against the oldest expected one.
  always @(posedge clk) begin : check_chars
    char_word_t want;
    took_word = !rst && char_ch.valid && char_ch.ready;
    if (took_word) begin
      if (text_due.size() == 0) begin
        note_mismatch("unexpected character", 0, char_ch.text_char);
      end else begin
        want = text_due.pop_front();
        if (char_ch.text_char !== want.text_char)
          note_mismatch("text_char", want.text_char, char_ch.text_char);
        if (char_ch.final_char !== want.final_char)
          note_mismatch("final_char", want.final_char, char_ch.final_char);
        if (char_ch.overflowed !== want.overflowed)
          note_mismatch("overflowed", want.overflowed, char_ch.overflowed);
      end
    end
  end

  // Receiver: a random wait after every word while idle_on is set, plus long holds on request.
  initial begin : char_sink
    int wait_left;
    int hold_left;
    int holds_done;
    wait_left = 0;
    hold_left = 0;
    holds_done = 0;
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_asks) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (took_word) wait_left = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_left > 0) begin
        char_ch.ready <= 1'b0;
        hold_left--;
      end else if (wait_left > 0) begin
        char_ch.ready <= 1'b0;
        wait_left--;
      end else begin
        char_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_short_strings();
    logic [7:0] singles [4];
    singles = '{8'h00, 8'h39, 8'h3A, 8'hFF};
    idle_on = 1'b0;
    foreach (singles[i]) begin
      str_len = 1;
      str_buf[0] = singles[i];
      send_string();
    end
    // A string of zero bytes encodes as ones only.
    str_len = 3;
    str_buf[0] = 8'h00;
    str_buf[1] = 8'h00;
    str_buf[2] = 8'h00;
    send_string();
    idle_on = 1'b1;
    str_len = 2;
    str_buf[0] = 8'h00;
    str_buf[1] = 8'h01;
    send_string();
    str_len = 3;
    str_buf[0] = 8'h00;
    str_buf[1] = 8'h80;
    str_buf[2] = 8'h00;
    send_string();
  endtask

  // Largest value the store holds; the end flag rides on a dropped byte.
  task automatic test_full_store();
    idle_on = 1'b0;
    str_len = STORE_BYTES + 1;
    for (int i = 0; i < STORE_BYTES; i++) str_buf[i] = FULL_BYTE;
    str_buf[STORE_BYTES] = ZERO_BYTE;
    send_string();
  endtask

  task automatic test_dropped_bytes();
    idle_on = 1'b1;
    str_len = STORE_BYTES + 3;
    for (int i = 0; i < str_len; i++) str_buf[i] = 8'($urandom_range(0, 255));
    send_string();
  endtask

  task automatic test_random_strings(input int item_goal);
    int start;
    start = sent_count;
    while (sent_count - start < item_goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      fill_random_string();
      send_string();
    end
  endtask

  // The receiver stalls while strings keep coming, so the block must stall its input.
  task automatic test_receiver_hold();
    idle_on = 1'b0;
    hold_asks++;
    for (int s = 0; s < 4; s++) begin
      str_len = 6;
      for (int i = 0; i < str_len; i++) str_buf[i] = 8'($urandom_range(0, 255));
      send_string();
    end
  endtask

  initial begin : run_tests
    held_count = 0;
    zero_prefix = 0;
    nonzero_seen = 1'b0;
    bytes_dropped = 1'b0;
    rst = 1'b1;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.end_of_string = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_short_strings();
    test_full_store();
    test_dropped_bytes();
    test_random_strings(80);
    test_receiver_hold();
    test_random_strings(75);

    byte_ch.valid <= 1'b0;
    while (text_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && text_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* files.f */
rtl/b58_pkg.sv
rtl/b58_byte_if.sv
rtl/b58_char_if.sv
rtl/b58_div_step.sv
rtl/base58_encoder_unit.sv
dv/tb_top.sv
